[sv/assert_macros.svh]
// Assertion macros shared by the write-pass corruptor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPLY(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that a trigger implies a condition in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

[sv/dwpc_pkg.sv]
// Types and constants of the disk write-pass corruptor.
package dwpc_pkg;

    // Input mode codes carried in s_tuser
    typedef enum logic [1:0] {
        MODE_RESEED = 2'd0,
        MODE_PASS   = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Classified command held in the queue
    typedef enum logic [1:0] {
        OP_RESEED = 2'd0,
        OP_PASS   = 2'd1,
        OP_DATA   = 2'd2
    } op_t;

    // Result kinds carried in m_tuser
    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_TRACK  = 2'd1;
    localparam logic [1:0] CFG_SECTOR = 2'd2;

    // Generator constants
    localparam logic [31:0] RNG_DEFAULT = 32'h0000_1541;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    // Byte shaping constants
    localparam logic [7:0] SPLICE_XOR_BASE = 8'h11;
    localparam int unsigned MOD_ERASE  = 17;
    localparam int unsigned MOD_ROTATE = 41;
    localparam int unsigned ERASE_CNT_W  = $clog2(MOD_ERASE);
    localparam int unsigned ROTATE_CNT_W = $clog2(MOD_ROTATE);

    // Command queue depth
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        op_t        op;
        logic [7:0] bias;
        logic [7:0] pass_num;
        logic [7:0] data_byte;
    } cmd_t;

    // Only the sector byte reaches the slot bits; the track byte is not held here
    typedef struct packed {
        logic [31:0] seed_value;
        logic [7:0]  sector_number;
    } cfg_t;

    // One xorshift32 step
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

[sv/dwpc_front.sv]
// Front end: accept stream transfers, classify them and compute the pass bias.
module dwpc_front
    import dwpc_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // revision[7:0], pass_index[15:8], data_byte[23:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [7:0] revision;
    logic [7:0] rev_inc;
    logic       keep;

    assign revision = s_tdata[7:0];
    assign rev_inc  = revision + 8'd1;
    assign s_tready = !q_full;

    // Classify the mode; drop the unused code
    always_comb begin
        q_cmd.op = OP_DATA;
        keep     = 1'b1;
        unique case (mode_t'(s_tuser))
            MODE_RESEED: q_cmd.op = OP_RESEED;
            MODE_PASS:   q_cmd.op = OP_PASS;
            MODE_DATA:   q_cmd.op = OP_DATA;
            default:     keep     = 1'b0;
        endcase
    end

    // bias = (revision + 1) * 3 mod 256
    assign q_cmd.bias      = {rev_inc[6:0], 1'b0} + rev_inc;
    assign q_cmd.pass_num  = s_tdata[15:8];
    assign q_cmd.data_byte = s_tdata[23:16];
    assign q_push          = s_tvalid && s_tready && keep;

endmodule

[sv/dwpc_queue.sv]
// Short command queue between the front end and the back end.
`include "assert_macros.svh"
module dwpc_queue
    import dwpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_no_overflow, aclk, aresetn, push, !full)
    `ASSERT_IMPLY(a_no_underflow, aclk, aresetn, pop, head_valid)

endmodule

[sv/dwpc_back.sv]
// Back end: run commands against the generator and pass state, hold the result.
`include "assert_macros.svh"
module dwpc_back
    import dwpc_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out[7:0], splice_slot[12:8], erase_slot[16:13]
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last_byte
);

    localparam int unsigned POS_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    // Generator and pass state
    logic [31:0]             rng_reg, rng_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ERASE_CNT_W-1:0]  pos17_reg, pos17_next;
    logic [ROTATE_CNT_W-1:0] pos41_reg, pos41_next;
    logic                    active_reg, active_next;
    logic [7:0]              pass_reg, pass_next;
    logic [7:0]              bias_reg, bias_next;
    logic [4:0]              splice_reg, splice_next;
    logic [3:0]              erase_reg, erase_next;
    logic [4:0]              rotate_reg, rotate_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;

    logic        out_free;
    logic        exec;
    logic [31:0] r1, r2;
    logic [7:0]  pos_ext;
    logic        at_last;
    logic [7:0]  b1, b2, b3;
    logic [3:0]  low_adj;
    logic [3:0]  pass_x5;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (out_free || (q_cmd.op == OP_RESEED));
    assign exec     = q_pop;

    // Two generator draws for a pass start
    assign r1 = xorshift32(rng_reg);
    assign r2 = xorshift32(r1);

    assign pos_ext = 8'(pos_reg);
    assign at_last = (pos_reg == POS_W'(BUFFER_BYTES - 1));
    assign pass_x5 = q_cmd.pass_num[3:0] + {q_cmd.pass_num[1:0], 2'b00};

    // Shape a data byte: splice XOR, erase nibble, rotate
    always_comb begin
        b1 = q_cmd.data_byte;
        if (pos_ext[4:0] == splice_reg) begin
            b1 = q_cmd.data_byte ^ (SPLICE_XOR_BASE + bias_reg);
        end
        low_adj = b1[3:0] + pass_reg[3:0] + {2'b00, bias_reg[1:0]};
        b2 = b1;
        if (pos17_reg == ERASE_CNT_W'(erase_reg)) begin
            b2 = {b1[7:4], low_adj};
        end
        b3 = b2;
        if (pos41_reg == ROTATE_CNT_W'(rotate_reg)) begin
            b3 = {b2[6:0], b2[7]};
        end
    end

    // Execute the head command
    always_comb begin
        rng_next       = rng_reg;
        pos_next       = pos_reg;
        pos17_next     = pos17_reg;
        pos41_next     = pos41_reg;
        active_next    = active_reg;
        pass_next      = pass_reg;
        bias_next      = bias_reg;
        splice_next    = splice_reg;
        erase_next     = erase_reg;
        rotate_next    = rotate_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (exec) begin
            unique case (q_cmd.op)
                OP_RESEED: begin
                    rng_next = (cfg.seed_value == '0) ? RNG_DEFAULT : cfg.seed_value;
                end
                OP_PASS: begin
                    pos_next   = '0;
                    pos17_next = '0;
                    pos41_next = '0;
                    if (q_cmd.pass_num == '0) begin
                        active_next = 1'b0;
                    end else begin
                        rng_next    = r2;
                        splice_next = r1[4:0] + cfg.sector_number[4:0] + q_cmd.bias[4:0]
                                      + q_cmd.pass_num[4:0];
                        erase_next  = r2[3:0] + cfg.sector_number[4:1] + pass_x5;
                        rotate_next = cfg.sector_number[4:0] + q_cmd.pass_num[4:0];
                        bias_next   = q_cmd.bias;
                        pass_next   = q_cmd.pass_num;
                        active_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PASS;
                    out_byte_next  = '0;
                    out_last_next  = 1'b0;
                end
                OP_DATA: begin
                    if (at_last) begin
                        pos_next   = '0;
                        pos17_next = '0;
                        pos41_next = '0;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        pos17_next = (pos17_reg == ERASE_CNT_W'(MOD_ERASE - 1)) ?
                                     '0 : pos17_reg + 1'b1;
                        pos41_next = (pos41_reg == ROTATE_CNT_W'(MOD_ROTATE - 1)) ?
                                     '0 : pos41_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DATA;
                    out_byte_next  = active_reg ? b3 : q_cmd.data_byte;
                    out_last_next  = at_last;
                end
                default: begin
                    rng_next = rng_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg       <= RNG_DEFAULT;
            pos_reg       <= '0;
            pos17_reg     <= '0;
            pos41_reg     <= '0;
            active_reg    <= 1'b0;
            pass_reg      <= '0;
            bias_reg      <= '0;
            splice_reg    <= '0;
            erase_reg     <= '0;
            rotate_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rng_reg       <= rng_next;
            pos_reg       <= pos_next;
            pos17_reg     <= pos17_next;
            pos41_reg     <= pos41_next;
            active_reg    <= active_next;
            pass_reg      <= pass_next;
            bias_reg      <= bias_next;
            splice_reg    <= splice_next;
            erase_reg     <= erase_next;
            rotate_reg    <= rotate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    // Slots reflect the state after the step that produced the held result
    assign m_tdata  = {7'd0, erase_reg, splice_reg, out_byte_reg};

    `ASSERT_IMPLY(a_pos_origin, aclk, aresetn, pos_reg == '0,
                  (pos17_reg == '0) && (pos41_reg == '0))
    `ASSERT_ALWAYS(a_mod_bounds, aclk, aresetn,
                   (pos17_reg < ERASE_CNT_W'(MOD_ERASE)) &&
                   (pos41_reg < ROTATE_CNT_W'(MOD_ROTATE)))
    `ASSERT_IMPLY(a_result_pops, aclk, aresetn,
                  q_pop && (q_cmd.op != OP_RESEED), out_free)

endmodule

[sv/disk_write_pass_corruptor.sv]
// Top level of the disk write-pass corruptor: config registers, front, queue, back.
//
//   channel   direction  handshake           content
//   s_*       in         s_tvalid/s_tready   mode in tuser; revision, pass, byte in tdata
//   m_*       out        m_tvalid/m_tready   kind in tuser, last_byte in tlast; byte, slots
//   cfg_*     in         cfg_valid/cfg_ready register index and 32-bit write data
//
// One command per cycle is taken from the queue by the back end while the output is not
// stalled, so the block then sustains one input transfer per cycle; an input transfer is
// written into a queue slot and then into the output register, which drives m_tvalid.
// Reseed and unused-mode transfers produce no result. Synchronous active-low reset
// clears the queue, the pass state and the output register; no clearing pass is run.
// A stalled output holds the queue back; up to four commands wait before s_tready drops.
module disk_write_pass_corruptor
    import dwpc_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // revision[7:0], pass_index[15:8], data_byte[23:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out[7:0], splice_slot[12:8], erase_slot[16:13]
    output logic        m_tuser,   // kind
    output logic        m_tlast,   // last_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] seed_reg;
    logic [7:0]  sector_reg;
    cfg_t        cfg;
    logic        q_full;
    logic        q_push;
    cmd_t        push_cmd;
    logic        q_pop;
    logic        q_valid;
    cmd_t        head_cmd;

    assign cfg_ready = 1'b1;

    // Latch configuration writes; the track byte never reaches the slot bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            sector_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SEED:   seed_reg   <= cfg_data;
                CFG_SECTOR: sector_reg <= cfg_data[7:0];
                default:    seed_reg   <= seed_reg;
            endcase
        end
    end

    assign cfg.seed_value    = seed_reg;
    assign cfg.sector_number = sector_reg;

    dwpc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    dwpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    dwpc_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the disk write-pass corruptor stream block.
module tb;
    import dwpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RAND_PHASES    = 7;
    localparam int unsigned PHASE_ITEMS    = 145;

    // One input transfer as the stream carries it
    typedef struct packed {
        mode_t      mode;
        logic [7:0] revision;
        logic [7:0] pass_index;
        logic [7:0] data_byte;
    } sector_cmd_t;

    // One result transfer, field by field
    typedef struct packed {
        logic       kind;
        logic [7:0] data_out;
        logic       last_byte;
        logic [4:0] splice_slot;
        logic [3:0] erase_slot;
    } sector_res_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // revision[7:0], pass_index[15:8], data_byte[23:16]
    logic [1:0]  s_tuser   = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // data_out[7:0], splice_slot[12:8], erase_slot[16:13]
    logic        m_tuser;          // kind
    logic        m_tlast;          // last_byte
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    disk_write_pass_corruptor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Stimulus waiting to be driven and predicted results waiting to arrive
    sector_cmd_t cmd_q[$];
    sector_res_t sector_out_q[$];

    // Register copies
    logic [31:0] seed_reg   = '0;
    logic [7:0]  track_reg  = '0;
    logic [7:0]  sector_reg = '0;

    // Write-pass state
    logic [31:0] gen_word   = RNG_DEFAULT;
    logic [7:0]  byte_pos   = '0;
    logic        pass_on    = 1'b0;
    logic [7:0]  pass_num   = '0;
    logic [7:0]  bias_reg   = '0;
    logic [4:0]  splice_reg = '0;
    logic [3:0]  erase_reg  = '0;
    logic [4:0]  rot_reg    = '0;

    int unsigned mismatches   = 0;
    int unsigned stim_total   = 0;
    int unsigned settings     = 0;
    int unsigned pass_results = 0;
    int unsigned data_results = 0;
    int unsigned sector_wraps = 0;

    // xorshift32 step
    function automatic logic [31:0] advance_word(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        return t ^ (t << SHIFT_C);
    endfunction

    // Mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Advance the write-pass state by one accepted transfer and queue its result
    task automatic predict_sector_step(input sector_cmd_t c);
        logic [15:0] tag;
        logic [7:0]  bias;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [7:0]  b;
        sector_res_t res;
        case (c.mode)
            MODE_RESEED: begin
                gen_word = (seed_reg == 32'd0) ? RNG_DEFAULT : seed_reg;
            end
            MODE_PASS: begin
                byte_pos = '0;
                if (c.pass_index == 8'd0) begin
                    pass_on = 1'b0;
                end else begin
                    tag  = {track_reg, sector_reg};
                    bias = (c.revision + 8'd1) * 8'd3;
                    r1   = advance_word(gen_word);
                    r2   = advance_word(r1);
                    gen_word   = r2;
                    splice_reg = 5'(r1 + 32'(tag) + 32'(bias) + 32'(c.pass_index));
                    erase_reg  = 4'(r2 + 32'(tag >> 1) + 32'(c.pass_index) * 32'd5);
                    rot_reg    = 5'(32'(tag) + 32'(c.pass_index));
                    bias_reg   = bias;
                    pass_num   = c.pass_index;
                    pass_on    = 1'b1;
                end
                res.kind        = KIND_PASS;
                res.data_out    = '0;
                res.last_byte   = 1'b0;
                res.splice_slot = splice_reg;
                res.erase_slot  = erase_reg;
                sector_out_q.push_back(res);
            end
            MODE_DATA: begin
                b = c.data_byte;
                if (pass_on) begin
                    if (int'(byte_pos) % 32 == int'(splice_reg))
                        b = b ^ (SPLICE_XOR_BASE + bias_reg);
                    if (int'(byte_pos) % MOD_ERASE == int'(erase_reg))
                        b[3:0] = b[3:0] + pass_num[3:0] + 4'(bias_reg[1:0]);
                    if (int'(byte_pos) % MOD_ROTATE == int'(rot_reg))
                        b = {b[6:0], b[7]};
                end
                res.kind        = KIND_DATA;
                res.data_out    = b;
                res.last_byte   = (byte_pos == 8'hFF);
                res.splice_slot = splice_reg;
                res.erase_slot  = erase_reg;
                sector_out_q.push_back(res);
                byte_pos = byte_pos + 8'd1;
            end
            default: ;
        endcase
    endtask

    // Input driver: hold each transfer until accepted, then idle or advance
    sector_cmd_t cur_cmd;
    bit          in_flight = 1'b0;
    bit          src_quiet = 1'b0;
    int unsigned gap_left  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_flight = 1'b0;
        end else if (!in_flight || s_tready) begin
            if (in_flight) begin
                predict_sector_step(cur_cmd);
                in_flight = 1'b0;
            end
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                cur_cmd = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_cmd.mode;
                s_tdata  <= {cur_cmd.data_byte, cur_cmd.pass_index, cur_cmd.revision};
                in_flight = 1'b1;
                gap_left  = pick_gap(src_quiet);
                if ($urandom_range(0, 63) == 0)
                    src_quiet = !src_quiet;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure
    bit          snk_quiet  = 1'b0;
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap(snk_quiet);
            if ($urandom_range(0, 63) == 0)
                snk_quiet = !snk_quiet;
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        sector_res_t want;
        sector_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = m_tuser;
            got.data_out    = m_tdata[7:0];
            got.last_byte   = m_tlast;
            got.splice_slot = m_tdata[12:8];
            got.erase_slot  = m_tdata[16:13];
            if (sector_out_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d byte=%02h last=%0d splice=%0d erase=%0d",
                         $time, got.kind, got.data_out, got.last_byte, got.splice_slot,
                         got.erase_slot);
                mismatches++;
            end else begin
                want = sector_out_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected kind=%0d byte=%02h last=%0d splice=%0d erase=%0d",
                             $time, want.kind, want.data_out, want.last_byte, want.splice_slot,
                             want.erase_slot);
                    $display("%0t:          actual   kind=%0d byte=%02h last=%0d splice=%0d erase=%0d",
                             $time, got.kind, got.data_out, got.last_byte, got.splice_slot,
                             got.erase_slot);
                    mismatches++;
                end
                if (want.kind == KIND_PASS)
                    pass_results++;
                else
                    data_results++;
                if (want.last_byte)
                    sector_wraps++;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_cmd(input mode_t m, input logic [7:0] rev, input logic [7:0] pidx,
                             input logic [7:0] dbyte);
        sector_cmd_t c;
        c.mode       = m;
        c.revision   = rev;
        c.pass_index = pidx;
        c.data_byte  = dbyte;
        cmd_q.push_back(c);
        stim_total++;
    endtask

    // Register write; the block is idle whenever this is called
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SEED:   seed_reg   = val;
            CFG_TRACK:  track_reg  = val[7:0];
            CFG_SECTOR: sector_reg = val[7:0];
            default: ;
        endcase
    endtask

    // Wait until every transfer is accepted and every result is back, then let it settle
    task automatic drain_and_settle();
        while (cmd_q.size() != 0 || in_flight || sector_out_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] seed;
        logic [7:0]  trk;
        logic [7:0]  sec;
        logic [7:0]  pidx;
        int unsigned phase_start;
        int unsigned sel;
        int unsigned run_len;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: bytes with no pass, unused mode, zero pass index, extreme passes
        queue_cmd(MODE_DATA, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_DATA, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(MODE_RESEED, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_PASS, 8'h00, 8'h00, 8'h00);
        queue_cmd(MODE_DATA, 8'h00, 8'h00, 8'h5A);
        queue_cmd(MODE_PASS, 8'h00, 8'h01, 8'h00);
        for (int i = 0; i < 8; i++)
            queue_cmd(MODE_DATA, 8'h00, 8'h00, (i % 2 == 0) ? 8'h00 : 8'hFF);
        queue_cmd(MODE_PASS, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 8; i++)
            queue_cmd(MODE_DATA, 8'hFF, 8'hFF, (i % 2 == 0) ? 8'hFF : 8'($urandom));
        queue_cmd(MODE_UNUSED, 8'h00, 8'h00, 8'h00);
        drain_and_settle();

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    seed = 32'hFFFF_FFFF;
                    trk  = 8'hFF;
                    sec  = 8'hFF;
                end
                1: begin
                    seed = 32'h0;
                    trk  = 8'h00;
                    sec  = 8'h00;
                end
                default: begin
                    seed = $urandom;
                    trk  = 8'($urandom);
                    sec  = 8'($urandom);
                end
            endcase
            write_reg(CFG_SEED, seed);
            write_reg(CFG_TRACK, {24'h0, trk});
            write_reg(CFG_SECTOR, {24'h0, sec});
            settings++;

            queue_cmd(MODE_RESEED, 8'($urandom), 8'($urandom), 8'($urandom));
            phase_start = stim_total;
            while (stim_total - phase_start < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 8) begin
                    // noise: any mode, any content
                    queue_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom));
                end else if (sel < 12) begin
                    queue_cmd(MODE_RESEED, 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    // pass start followed by a run of sector bytes, sometimes past a wrap
                    pidx = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                    queue_cmd(MODE_PASS, 8'($urandom), pidx, 8'($urandom));
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(256, 300)
                                                          : $urandom_range(1, 60);
                    repeat (run_len)
                        queue_cmd(MODE_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            drain_and_settle();
        end

        $display("Drove %0d input transfers over %0d register settings plus reset defaults.",
                 stim_total, settings);
        $display("Checked %0d pass reports and %0d sector bytes, %0d of them at a sector wrap.",
                 pass_results, data_results, sector_wraps);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
